@@ design/unsigned_to_radix_ascii_assert.svh @@
// assertion macros used by the unsigned_to_radix_ascii top-level design file
// expects clk and rst_n in the scope where a macro is used
`ifndef UNSIGNED_TO_RADIX_ASCII_ASSERT_SVH
`define UNSIGNED_TO_RADIX_ASCII_ASSERT_SVH

// same-cycle implication, checked outside reset
`define U2RA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2ra assertion failed");

// next-cycle implication, checked outside reset
`define U2RA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2ra assertion failed");

`endif

@@ design/u2ra_pkg.sv @@
// u2ra_pkg: widths, constants, state type and digit helpers
// for the unsigned_to_radix_ascii block; no dependencies
package u2ra_pkg;

    localparam int VALUE_W         = 64;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 6;
    localparam int MAX_DIGIT_COUNT = 64;
    localparam int IDX_W           = $clog2(MAX_DIGIT_COUNT);
    localparam int COUNT_W         = $clog2(MAX_DIGIT_COUNT + 1);
    localparam int BITS_PER_CYCLE  = 8;
    localparam int DIV_CYCLES      = VALUE_W / BITS_PER_CYCLE;
    localparam int STEP_W          = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_MIN      = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX      = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0]  ASCII_UPPER_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0]  ASCII_NINE     = 8'h39;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    function automatic logic radix_valid(input logic [RADIX_W-1:0] r);
        return (r >= RADIX_MIN) && (r <= RADIX_MAX);
    endfunction

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DECIMAL_DIGITS)
        begin
            return ASCII_ZERO + d_ext;
        end
        return ASCII_UPPER_A - CHAR_W'(DECIMAL_DIGITS) + d_ext;
    endfunction

endpackage

@@ design/unsigned_to_radix_ascii.sv @@
// unsigned_to_radix_ascii: top level, sequencer around the divider and digit buffer
// depends on u2ra_pkg, u2ra_divider, u2ra_digit_mem, unsigned_to_radix_ascii_assert.svh
//
// usage
// a transaction is taken at a rising edge with start high and busy low; value and
// radix are sampled there. the block then divides value by radix again and again,
// one digit per pass, storing each remainder in the digit buffer, and afterwards
// plays the digits back most significant first. each digit appears for one cycle
// with strobe high; last marks the final one. a zero value gives the single
// digit '0'. a radix outside 2..36 gives one result, in the cycle after start, with
// bad_radix and last set and digit_char zero.
// the divider is restarted for each digit, and the first digit is shown only
// after the last division. a conversion has at most 64 digits, which radix 2
// can reach. busy stays high until the last result has been shown.
// results cannot be held off: the receiver must take each one in its cycle.
// reset clears the sequencer and the result strobes; the digit buffer is not
// cleared and needs no clearing, since every digit is written before it is read.
`include "unsigned_to_radix_ascii_assert.svh"

module unsigned_to_radix_ascii
    import u2ra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    input  logic [RADIX_W-1:0] radix,
    output logic               strobe,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last,
    output logic               bad_radix
);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               emit_v_reg, emit_v_next;
    logic               emit_last_reg, emit_last_next;
    logic               err_reg, err_next;

    logic               accept;
    logic               radix_ok;
    logic               more_digits;
    logic               digit_ok;

    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    logic [RADIX_W-1:0] div_divisor;
    logic               div_running;
    logic               div_done;
    logic [VALUE_W-1:0] div_quotient;
    logic [DIGIT_W-1:0] div_remainder;

    logic               wr_en;
    logic               rd_en;
    logic [DIGIT_W-1:0] rd_data;

    u2ra_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .running   (div_running),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    u2ra_digit_mem u_digit_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (div_remainder),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign busy        = (state_reg != ST_IDLE) || emit_v_reg || err_reg;
    assign accept      = start && !busy;
    assign radix_ok    = radix_valid(radix);
    assign more_digits = (div_quotient != '0) &&
                         (cnt_reg != COUNT_W'(MAX_DIGIT_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && radix_ok)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done && !more_digits)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath control
    always_comb
    begin
        div_start      = 1'b0;
        div_dividend   = value;
        div_divisor    = radix_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        radix_next     = radix_reg;
        emit_v_next    = 1'b0;
        emit_last_next = 1'b0;
        err_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                div_divisor = radix;
                if (accept)
                begin
                    if (radix_ok)
                    begin
                        div_start  = 1'b1;
                        radix_next = radix;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                div_dividend = div_quotient;
                if (div_done)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + COUNT_W'(1);
                    if (more_digits)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        idx_next = cnt_reg[IDX_W-1:0];
                    end
                end
            end
            ST_EMIT:
            begin
                rd_en          = 1'b1;
                emit_v_next    = 1'b1;
                emit_last_next = (idx_reg == '0);
                idx_next       = idx_reg - IDX_W'(1);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            emit_v_reg    <= 1'b0;
            emit_last_reg <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            emit_v_reg    <= emit_v_next;
            emit_last_reg <= emit_last_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
    end

    assign strobe     = emit_v_reg || err_reg;
    assign digit_char = err_reg ? '0 : to_ascii(rd_data);
    assign last       = emit_last_reg || err_reg;
    assign bad_radix  = err_reg;

    assign digit_ok = ((digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE)) ||
                      ((digit_char >= ASCII_UPPER_A) && (digit_char <= ASCII_UPPER_Z));

    `U2RA_ASSERT_NEXT(a_bad_radix_result, accept && !radix_ok, strobe && bad_radix && last)
    `U2RA_ASSERT_NEXT(a_last_ends_burst, strobe && last, !strobe)
    `U2RA_ASSERT_SAME(a_divider_in_div_state, div_running, state_reg == ST_DIV)
    `U2RA_ASSERT_SAME(a_digit_in_range, strobe && !bad_radix, digit_ok)
    `U2RA_ASSERT_SAME(a_count_bound, state_reg == ST_DIV, cnt_reg < COUNT_W'(MAX_DIGIT_COUNT))

endmodule

@@ design/u2ra_divider.sv @@
// u2ra_divider: iterative restoring divider, 64-bit dividend by 6-bit divisor
// retires BITS_PER_CYCLE quotient bits per clock; depends on u2ra_pkg
module u2ra_divider
    import u2ra_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [VALUE_W-1:0]  dividend,
    input  logic [RADIX_W-1:0]  divisor,
    output logic                running,
    output logic                done,
    output logic [VALUE_W-1:0]  quotient,
    output logic [DIGIT_W-1:0]  remainder
);

    logic [VALUE_W-1:0] dq_reg, dq_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               running_reg, running_next;
    logic               done_reg, done_next;

    logic [VALUE_W-1:0] dq_work;
    logic [DIGIT_W-1:0] rem_work;
    logic [RADIX_W:0]   partial;
    logic               last_step;

    // chain of BITS_PER_CYCLE compare-subtract steps, one per quotient bit
    always_comb
    begin
        dq_work  = dq_reg;
        rem_work = rem_reg;
        partial  = '0;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            partial = {rem_work, dq_work[VALUE_W-1]};
            dq_work = {dq_work[VALUE_W-2:0], 1'b0};
            if (partial >= {1'b0, div_reg})
            begin
                rem_work   = DIGIT_W'(partial - {1'b0, div_reg});
                dq_work[0] = 1'b1;
            end
            else
            begin
                rem_work = partial[DIGIT_W-1:0];
            end
        end
    end

    assign last_step = (step_reg == STEP_W'(DIV_CYCLES - 1));

    always_comb
    begin
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        step_next    = step_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (start)
        begin
            dq_next      = dividend;
            rem_next     = '0;
            div_next     = divisor;
            step_next    = '0;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            dq_next      = dq_work;
            rem_next     = rem_work;
            step_next    = step_reg + STEP_W'(1);
            running_next = !last_step;
            done_next    = last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign running   = running_reg;
    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

@@ design/u2ra_digit_mem.sv @@
// u2ra_digit_mem: digit buffer, one write and one registered read per cycle
// depends on u2ra_pkg for depth and digit width
module u2ra_digit_mem
    import u2ra_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [DIGIT_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [DIGIT_W-1:0] rd_data
);

    logic [DIGIT_W-1:0] mem [MAX_DIGIT_COUNT];
    logic [DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
